[rtl/core/nic_pkg.sv]
// nic_pkg: status codes, byte classes and result type for the identifier checker
`timescale 1ns / 1ps
package nic_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SEP   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_BAD_LEAD = 3'd4;
  localparam logic [2:0] ST_BAD_CHAR = 3'd5;

  localparam logic [1:0] PERR_NONE  = 2'd0;
  localparam logic [1:0] PERR_LEAD  = 2'd1;
  localparam logic [1:0] PERR_CHAR  = 2'd2;
  localparam logic [1:0] PERR_EMPTY = 2'd3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  localparam int OUT_LEN_W = 7;

  typedef struct packed {
    logic [2:0]           status;
    logic [OUT_LEN_W-1:0] namespace_length;
    logic [OUT_LEN_W-1:0] total_length;
  } res_t;

  function automatic logic is_lead_ok(input logic [7:0] c);
    is_lead_ok = (c >= CH_LC_A && c <= CH_LC_Z) || c == CH_UNDER;
  endfunction

  function automatic logic is_body_ok(input logic [7:0] c);
    is_body_ok = is_lead_ok(c) || (c >= CH_DIG_0 && c <= CH_DIG_9);
  endfunction

  function automatic logic [2:0] part_status(input logic empty, input logic [1:0] err);
    logic [2:0] s;
    s = ST_OK;
    if (empty) begin
      s = ST_EMPTY;
    end else if (err == PERR_LEAD) begin
      s = ST_BAD_LEAD;
    end else if (err == PERR_CHAR) begin
      s = ST_BAD_CHAR;
    end
    part_status = s;
  endfunction

endpackage

[rtl/core/namespaced_identifier_checker.sv]
// namespaced_identifier_checker: per-byte identifier check with a two-word result buffer
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | valid / stall          | character[7:0], last_char
//  result   | status_valid / _stall  | status[2:0], namespace_length, total_length
//
// One byte per cycle when not stalled; class test and counter update sit between port and state.
// The final byte of an identifier writes its result word the cycle it is accepted.
// Results sit in a main register plus a skid register; stall rises only with the skid full.
// Synchronous reset clears the parse state and the valid flags of both result registers.
`timescale 1ns / 1ps
module namespaced_identifier_checker #(
  parameter int MAX_LENGTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         stall,
  input  logic [7:0]                   character,
  input  logic                         last_char,
  output logic                         status_valid,
  input  logic                         status_stall,
  output logic [2:0]                   status,
  output logic [nic_pkg::OUT_LEN_W-1:0] namespace_length,
  output logic [nic_pkg::OUT_LEN_W-1:0] total_length
);
  import nic_pkg::*;

  localparam int CW_RAW = $clog2(MAX_LENGTH + 2);
  localparam int CW     = (CW_RAW < OUT_LEN_W) ? OUT_LEN_W : CW_RAW;
  localparam logic [CW-1:0] SAT = CW'(MAX_LENGTH + 1);
  localparam logic [CW-1:0] LIM = CW'(MAX_LENGTH);

  logic          separator_seen, separator_seen_next;
  logic          part_first_pending, part_first_pending_next;
  logic [CW-1:0] length_count, length_count_next;
  logic [CW-1:0] namespace_count, namespace_count_next;
  logic [1:0]    namespace_error, namespace_error_next;
  logic [1:0]    name_error, name_error_next;

  logic accept, produce, pop;
  logic skid_valid;
  res_t main_word, skid_word, new_word;
  logic [2:0] st;
  logic [1:0] cur_err, upd_err;

  assign accept  = valid && !stall;
  assign produce = accept && last_char;
  assign pop     = status_valid && !status_stall;
  assign stall   = skid_valid;

  always_comb begin
    separator_seen_next     = separator_seen;
    part_first_pending_next = part_first_pending;
    namespace_count_next    = namespace_count;
    namespace_error_next    = namespace_error;
    name_error_next         = name_error;
    length_count_next       = (length_count < SAT) ? length_count + 1'b1 : length_count;
    cur_err                 = separator_seen ? name_error : namespace_error;
    upd_err                 = cur_err;

    if (!separator_seen && character == CH_COLON) begin
      separator_seen_next     = 1'b1;
      part_first_pending_next = 1'b1;
      if (part_first_pending) begin
        namespace_error_next = PERR_EMPTY;
      end
    end else begin
      if (!separator_seen) begin
        namespace_count_next = (namespace_count < SAT) ? namespace_count + 1'b1
                                                       : namespace_count;
      end
      if (cur_err == PERR_NONE) begin
        if (part_first_pending) begin
          if (!is_lead_ok(character)) begin
            upd_err = PERR_LEAD;
          end
        end else if (!is_body_ok(character)) begin
          upd_err = PERR_CHAR;
        end
      end
      if (separator_seen) begin
        name_error_next = upd_err;
      end else begin
        namespace_error_next = upd_err;
      end
      part_first_pending_next = 1'b0;
    end

    if (!separator_seen_next) begin
      st = ST_NO_SEP;
    end else if (length_count_next > LIM) begin
      st = ST_TOO_LONG;
    end else begin
      st = part_status(namespace_error_next == PERR_EMPTY, namespace_error_next);
      if (st == ST_OK) begin
        st = part_status(part_first_pending_next, name_error_next);
      end
    end

    new_word.status           = st;
    new_word.namespace_length = namespace_count_next[OUT_LEN_W-1:0];
    new_word.total_length     = length_count_next[OUT_LEN_W-1:0];
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst || produce) begin
      separator_seen     <= 1'b0;
      part_first_pending <= 1'b1;
      length_count       <= '0;
      namespace_count    <= '0;
      namespace_error    <= PERR_NONE;
      name_error         <= PERR_NONE;
    end else if (accept) begin
      separator_seen     <= separator_seen_next;
      part_first_pending <= part_first_pending_next;
      length_count       <= length_count_next;
      namespace_count    <= namespace_count_next;
      namespace_error    <= namespace_error_next;
      name_error         <= name_error_next;
    end
  end

  // result word buffer: main register feeds the port, skid catches a word while main is held
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!status_valid || pop) begin
      if (skid_valid) begin
        status_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        status_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!status_valid || pop) begin
      if (skid_valid) begin
        main_word <= skid_word;
      end else if (produce) begin
        main_word <= new_word;
      end
    end else if (produce) begin
      skid_word <= new_word;
    end
  end

  assign status           = main_word.status;
  assign namespace_length = main_word.namespace_length;
  assign total_length     = main_word.total_length;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> status_valid)
    else $error("skid word held with main register empty");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    produce |=> (length_count == '0 && !separator_seen && part_first_pending))
    else $error("parse state not cleared after final byte");

  a_word_written: assert property (@(posedge clk) disable iff (rst)
    (produce && !status_valid) |=> status_valid)
    else $error("final byte gave no result word");

  a_held_word: assert property (@(posedge clk) disable iff (rst)
    (status_valid && status_stall) |=> status_valid)
    else $error("stalled result word dropped");

endmodule

[test/namespaced_identifier_checker_test.sv]
// Self-checking testbench for the namespaced identifier checker: byte stimulus, status prediction
`timescale 1ns / 1ps
module namespaced_identifier_checker_test;
  import nic_pkg::*;

  localparam int LIMIT = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       drain;
  } char_item_t;

  typedef struct packed {
    logic       sep_seen;
    logic       first_pending;
    logic [6:0] len;
    logic [6:0] ns_len;
    logic [1:0] ns_err;
    logic [1:0] nm_err;
  } parse_t;

  logic       clk;
  logic       rst;
  logic       valid;
  logic       stall;
  logic [7:0] character;
  logic       last_char;
  logic       status_valid;
  logic       status_stall;
  logic [2:0] status;
  logic [OUT_LEN_W-1:0] namespace_length;
  logic [OUT_LEN_W-1:0] total_length;

  char_item_t pending_bytes[$];
  res_t       status_expected[$];
  parse_t     parser;
  int         mismatches = 0;

  namespaced_identifier_checker #(.MAX_LENGTH(LIMIT)) DUT (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall),
    .character(character), .last_char(last_char),
    .status_valid(status_valid), .status_stall(status_stall),
    .status(status), .namespace_length(namespace_length), .total_length(total_length)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // ---- prediction ----
  function automatic logic [1:0] grade_char(input logic [7:0] c, input logic first);
    logic lead_ok;
    logic body_ok;
    lead_ok = (c >= CH_LC_A && c <= CH_LC_Z) || c == CH_UNDER;
    body_ok = lead_ok || (c >= CH_DIG_0 && c <= CH_DIG_9);
    if (first && !lead_ok) return PERR_LEAD;
    if (!first && !body_ok) return PERR_CHAR;
    return PERR_NONE;
  endfunction

  function automatic logic [2:0] part_verdict(input logic empty, input logic [1:0] err);
    if (empty) return ST_EMPTY;
    if (err == PERR_LEAD) return ST_BAD_LEAD;
    if (err == PERR_CHAR) return ST_BAD_CHAR;
    return ST_OK;
  endfunction

  function automatic void clear_parser();
    parser = '{sep_seen: 1'b0, first_pending: 1'b1, len: '0, ns_len: '0,
               ns_err: PERR_NONE, nm_err: PERR_NONE};
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic fin);
    res_t       w;
    logic [2:0] st;
    if (parser.len < LIMIT + 1) parser.len = parser.len + 7'd1;
    if (!parser.sep_seen && c == CH_COLON) begin
      if (parser.first_pending) parser.ns_err = PERR_EMPTY;
      parser.sep_seen = 1'b1;
      parser.first_pending = 1'b1;
    end else begin
      if (!parser.sep_seen) begin
        if (parser.ns_len < LIMIT + 1) parser.ns_len = parser.ns_len + 7'd1;
        if (parser.ns_err == PERR_NONE) parser.ns_err = grade_char(c, parser.first_pending);
      end else if (parser.nm_err == PERR_NONE) begin
        parser.nm_err = grade_char(c, parser.first_pending);
      end
      parser.first_pending = 1'b0;
    end
    if (fin) begin
      if (!parser.sep_seen) begin
        st = ST_NO_SEP;
      end else if (parser.len > LIMIT) begin
        st = ST_TOO_LONG;
      end else begin
        st = part_verdict(parser.ns_err == PERR_EMPTY, parser.ns_err);
        if (st == ST_OK) st = part_verdict(parser.first_pending, parser.nm_err);
      end
      w.status = st;
      w.namespace_length = parser.ns_len;
      w.total_length = parser.len;
      status_expected.push_back(w);
      clear_parser();
    end
  endfunction

  // ---- stimulus building ----
  function automatic logic [7:0] lead_pick();
    int r;
    r = $urandom_range(0, 26);
    return (r == 26) ? CH_UNDER : CH_LC_A + 8'(r);
  endfunction

  function automatic logic [7:0] body_pick();
    int r;
    r = $urandom_range(0, 36);
    if (r < 26) return CH_LC_A + 8'(r);
    if (r < 36) return CH_DIG_0 + 8'(r - 26);
    return CH_UNDER;
  endfunction

  task automatic push_ident(input logic [7:0] ident[$], input logic drain);
    char_item_t it;
    foreach (ident[i]) begin
      it.ch = ident[i];
      it.fin = (i == ident.size() - 1);
      it.drain = drain && (i == 0);
      pending_bytes.push_back(it);
    end
  endtask

  task automatic push_text(input string s);
    logic [7:0] ident[$];
    for (int i = 0; i < s.len(); i++) ident.push_back(s[i]);
    push_ident(ident, 1'b0);
  endtask

  task automatic add_part(inout logic [7:0] ident[$], input int n);
    for (int i = 0; i < n; i++) ident.push_back(i == 0 ? lead_pick() : body_pick());
  endtask

  task automatic add_run(inout logic [7:0] ident[$], input logic [7:0] c, input int n);
    for (int i = 0; i < n; i++) ident.push_back(c);
  endtask

  task automatic build_directed();
    logic [7:0] ident[$];
    push_text("ns:name");
    push_text("_a9:_z0");
    push_text("abc");
    push_text(":abc");
    push_text("abc:");
    push_text(":");
    push_text("9ab:x");
    push_text("a{b:x");
    push_text("ab:`x");
    push_text("ab:x/");
    push_text("a:b:c");
    push_text("A:b");
    ident = '{8'h00, CH_COLON, 8'hFF};
    push_ident(ident, 1'b0);
    ident = '{CH_LC_A, CH_COLON, CH_LC_Z, 8'hFF};
    push_ident(ident, 1'b0);
    // 64 bytes: at the limit
    ident = {};
    add_run(ident, CH_LC_A, 30);
    ident.push_back(CH_COLON);
    add_run(ident, CH_LC_Z, 33);
    push_ident(ident, 1'b0);
    // 65 bytes: one over, with a bad namespace that must not win
    ident = {};
    add_run(ident, CH_DIG_0, 31);
    ident.push_back(CH_COLON);
    add_run(ident, CH_LC_Z, 33);
    push_ident(ident, 1'b0);
    // long namespace, counters saturate, colon at the very end
    ident = {};
    add_run(ident, CH_UNDER, 80);
    ident.push_back(CH_COLON);
    push_ident(ident, 1'b0);
    // long with no colon at all
    ident = {};
    add_run(ident, CH_LC_Z, 90);
    push_ident(ident, 1'b0);
  endtask

  task automatic build_random(input int target);
    logic [7:0] ident[$];
    int         count;
    int         kind;
    int         n;
    logic       drain;
    count = 0;
    while (count < target) begin
      ident = {};
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_part(ident, $urandom_range(1, 10));
        ident.push_back(CH_COLON);
        add_part(ident, $urandom_range(1, 10));
        if (kind >= 55) ident[$urandom_range(0, ident.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 78) begin
        add_part(ident, $urandom_range(1, 12));
      end else if (kind < 84) begin
        if ($urandom_range(0, 1)) begin
          ident.push_back(CH_COLON);
          add_part(ident, $urandom_range(0, 6));
        end else begin
          add_part(ident, $urandom_range(1, 6));
          ident.push_back(CH_COLON);
        end
      end else if (kind < 90) begin
        n = $urandom_range(1, 40);
        add_part(ident, n);
        ident.push_back(CH_COLON);
        add_part(ident, $urandom_range(57, 71) - n);
      end else if (kind < 93) begin
        add_part(ident, $urandom_range(60, 100));
        if ($urandom_range(0, 1)) begin
          ident.push_back(CH_COLON);
          add_part(ident, $urandom_range(0, 5));
        end
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          ident.push_back($urandom_range(0, 3) == 0 ? CH_COLON : 8'($urandom_range(0, 255)));
      end
      drain = (count == 0) || ($urandom_range(0, 49) == 0);
      push_ident(ident, drain);
      count += ident.size();
    end
  endtask

  // ---- driver ----
  int         burst_left = 8;
  int         gap_left = 0;
  logic       drv_valid;
  char_item_t drv_item;

  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      character <= 8'h00;
      last_char <= 1'b0;
      clear_parser();
    end else begin
      drv_valid = valid;
      drv_item.ch = character;
      drv_item.fin = last_char;
      if (valid && !stall) begin
        parse_char(character, last_char);
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain && status_expected.size() > 0)) begin
          drv_item = pending_bytes.pop_front();
          drv_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      valid <= drv_valid;
      character <= drv_item.ch;
      last_char <= drv_item.fin;
    end
  end

  // ---- receiver stall pattern, with one long hold-off ----
  int   rx_cycle = 0;
  int   hold_left = 0;
  int   rx_mode = 0;
  int   mode_left = 0;
  logic rx_stall;

  always @(posedge clk) begin
    if (rst) begin
      status_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 1200) hold_left = 400;
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rx_stall = 1'b1;
      end else begin
        case (rx_mode)
          0: rx_stall = 1'b0;
          1: rx_stall = ($urandom_range(0, 3) == 0);
          2: rx_stall = ($urandom_range(0, 3) != 0);
          default: rx_stall = rx_cycle[0];
        endcase
      end
      status_stall <= rx_stall;
    end
  end

  // ---- monitor ----
  task automatic report_mismatch(input string field, input int exp_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", field, exp_v, got_v, $realtime);
  endtask

  res_t want;

  always @(posedge clk) begin
    if (!rst && status_valid && !status_stall) begin
      if (status_expected.size() == 0) begin
        report_mismatch("unexpected word, status", -1, int'(status));
      end else begin
        want = status_expected.pop_front();
        if (status !== want.status)
          report_mismatch("status", int'(want.status), int'(status));
        if (namespace_length !== want.namespace_length)
          report_mismatch("namespace_length", int'(want.namespace_length),
                          int'(namespace_length));
        if (total_length !== want.total_length)
          report_mismatch("total_length", int'(want.total_length), int'(total_length));
      end
    end
  end

  // ---- sequencing ----
  initial begin
    build_directed();
    build_random(1450 - pending_bytes.size());
    @(negedge rst);
    while (pending_bytes.size() > 0 || valid || status_expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (status_expected.size() > 0) report_mismatch("words left over", 0, status_expected.size());
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/nic_pkg.sv
rtl/core/namespaced_identifier_checker.sv
test/namespaced_identifier_checker_test.sv
